// ----- sv/mtwc_pkg.sv -----
// shared types and constants for the motion triggered window capture
package mtwc_pkg;

    localparam int SAMPLE_W = 96;
    localparam int OUT_W    = 112;
    localparam int IDX_W    = 6;

    // stored frame, accel x in the lowest bits
    typedef struct packed {
        logic [16:0] rate_z;
        logic [16:0] rate_y;
        logic [16:0] rate_x;
        logic [15:0] accel_z;
        logic [15:0] accel_y;
        logic [15:0] accel_x;
    } t_frame;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] off_z;
    } t_cfg;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_OFF_X     = 2'd1;
    localparam logic [1:0] REG_OFF_Y     = 2'd2;
    localparam logic [1:0] REG_OFF_Z     = 2'd3;

    localparam logic [15:0] THRESHOLD_RST = 16'd8000;
    localparam logic [15:0] OFF_X_RST     = 16'd478;
    localparam logic [15:0] OFF_Y_RST     = 16'd100;
    localparam logic [15:0] OFF_Z_RST     = 16'd20;

    localparam logic [IDX_W-1:0] CNT_MAX = 6'd63;

endpackage

// ----- sv/mtwc_cfg.sv -----
// register file behind the configuration port
module mtwc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mtwc_pkg::t_cfg      o_cfg
);

    mtwc_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= mtwc_pkg::THRESHOLD_RST;
            r_cfg.off_x     <= mtwc_pkg::OFF_X_RST;
            r_cfg.off_y     <= mtwc_pkg::OFF_Y_RST;
            r_cfg.off_z     <= mtwc_pkg::OFF_Z_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                mtwc_pkg::REG_THRESHOLD: r_cfg.threshold <= pwdata[15:0];
                mtwc_pkg::REG_OFF_X:     r_cfg.off_x     <= pwdata[15:0];
                mtwc_pkg::REG_OFF_Y:     r_cfg.off_y     <= pwdata[15:0];
                mtwc_pkg::REG_OFF_Z:     r_cfg.off_z     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mtwc_pkg::REG_THRESHOLD: prdata = {16'd0, r_cfg.threshold};
            mtwc_pkg::REG_OFF_X:     prdata = {16'd0, r_cfg.off_x};
            mtwc_pkg::REG_OFF_Y:     prdata = {16'd0, r_cfg.off_y};
            mtwc_pkg::REG_OFF_Z:     prdata = {16'd0, r_cfg.off_z};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/mtwc_front.sv -----
// gyro offset correction and motion trigger detection
module mtwc_front (
    input  logic [mtwc_pkg::SAMPLE_W-1:0] i_tdata,
    input  mtwc_pkg::t_cfg                i_cfg,
    output mtwc_pkg::t_frame              o_frame,
    output logic                          o_hit
);

    logic [15:0] w_rate_x, w_rate_y, w_rate_z;
    logic [16:0] w_cor_x, w_cor_y, w_cor_z;
    logic [16:0] w_mag_x, w_mag_y, w_mag_z;
    logic [16:0] w_thr;

    assign w_rate_x = i_tdata[63:48];
    assign w_rate_y = i_tdata[79:64];
    assign w_rate_z = i_tdata[95:80];

    // sign-extended 17-bit sums are exact
    assign w_cor_x = {w_rate_x[15], w_rate_x} + {i_cfg.off_x[15], i_cfg.off_x};
    assign w_cor_y = {w_rate_y[15], w_rate_y} + {i_cfg.off_y[15], i_cfg.off_y};
    assign w_cor_z = {w_rate_z[15], w_rate_z} + {i_cfg.off_z[15], i_cfg.off_z};

    // magnitude as 17-bit unsigned, most negative value maps to 65536
    assign w_mag_x = w_cor_x[16] ? (17'd0 - w_cor_x) : w_cor_x;
    assign w_mag_y = w_cor_y[16] ? (17'd0 - w_cor_y) : w_cor_y;
    assign w_mag_z = w_cor_z[16] ? (17'd0 - w_cor_z) : w_cor_z;

    assign w_thr = {1'b0, i_cfg.threshold};
    assign o_hit = (w_mag_x > w_thr) || (w_mag_y > w_thr) || (w_mag_z > w_thr);

    assign o_frame.accel_x = i_tdata[15:0];
    assign o_frame.accel_y = i_tdata[31:16];
    assign o_frame.accel_z = i_tdata[47:32];
    assign o_frame.rate_x  = w_cor_x;
    assign o_frame.rate_y  = w_cor_y;
    assign o_frame.rate_z  = w_cor_z;

endmodule

// ----- sv/mtwc_ring.sv -----
// frame ring memory, one write and one registered read port, unwritten entries read zero
module mtwc_ring #(
    parameter int DEPTH  = 60,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  mtwc_pkg::t_frame  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output mtwc_pkg::t_frame  o_rdata
);

    mtwc_pkg::t_frame r_mem [0:DEPTH-1];
    mtwc_pkg::t_frame r_rdata;
    logic [DEPTH-1:0] r_valid;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ----- sv/motion_triggered_window_capture.sv -----
// motion triggered window capture: a sample is accepted whenever one is valid and no dump runs
// a dump emits WINDOW_FRAMES frames, a read issued only once the last has landed and the output is free,
// set by the single ring read port with one read in flight ahead of the output register
// the trigger sets the dump state, which issues the first read; its data passes the ring and output registers
// synchronous active-low reset clears control, config to defaults, ring reads zero
// ring clearing is immediate through per-entry valid bits, no clearing pass
module motion_triggered_window_capture #(
    parameter int WINDOW_FRAMES = 60,
    parameter int PRE_FRAMES    = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [mtwc_pkg::SAMPLE_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_index, out_accel_x/y/z, out_rate_x/y/z, zero pad
    output logic [mtwc_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int ADDR_W = (WINDOW_FRAMES > 2) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int TARGET = WINDOW_FRAMES - PRE_FRAMES;
    localparam logic [mtwc_pkg::IDX_W-1:0] TGT_CNT =
        mtwc_pkg::IDX_W'((TARGET > 0) ? TARGET : 0);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_FRAMES - 1);
    localparam logic [mtwc_pkg::IDX_W-1:0] LAST_IDX = mtwc_pkg::IDX_W'(WINDOW_FRAMES - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    mtwc_pkg::t_cfg   w_cfg;
    mtwc_pkg::t_frame w_frame;
    mtwc_pkg::t_frame w_rdata;
    logic             w_hit;
    logic             w_acc;
    logic             w_rd_issue;
    logic [ADDR_W-1:0] w_wp_inc;
    logic [ADDR_W-1:0] w_rd_inc;
    logic [mtwc_pkg::IDX_W-1:0] w_cnt_inc;

    logic                        r_state, n_state;
    logic [ADDR_W-1:0]           r_wp, n_wp;
    logic                        r_armed, n_armed;
    logic [mtwc_pkg::IDX_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0]           r_rd_addr, n_rd_addr;
    logic [mtwc_pkg::IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic                        r_inflight;
    logic [mtwc_pkg::IDX_W-1:0]  r_inf_idx;
    logic                        r_inf_last;
    logic                        r_ovalid;
    logic [mtwc_pkg::IDX_W-1:0]  r_oidx;
    logic                        r_olast;
    mtwc_pkg::t_frame            r_oframe;

    mtwc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mtwc_front u_front (
        .i_tdata (s_axis_tdata),
        .i_cfg   (w_cfg),
        .o_frame (w_frame),
        .o_hit   (w_hit)
    );

    mtwc_ring #(
        .DEPTH  (WINDOW_FRAMES),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_acc),
        .i_waddr (r_wp),
        .i_wdata (w_frame),
        .i_re    (w_rd_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_wp_inc      = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
    assign w_rd_inc      = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;
    assign w_cnt_inc     = (r_cnt == mtwc_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_armed    = r_armed;
        n_cnt      = r_cnt;
        n_rd_addr  = r_rd_addr;
        n_rd_idx   = r_rd_idx;
        w_rd_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_wp = w_wp_inc;
                    if (!r_armed) begin
                        if (w_hit) begin
                            n_armed = 1'b1;
                            n_cnt   = '0;
                        end
                    end else begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= TGT_CNT) begin
                            // window starts at the oldest frame, just past the newest
                            n_armed   = 1'b0;
                            n_state   = ST_DUMP;
                            n_rd_addr = w_wp_inc;
                            n_rd_idx  = '0;
                        end
                    end
                end
            end
            ST_DUMP: begin
                // one read in flight, issued only when the output register frees up
                if (!r_inflight && (!r_ovalid || m_axis_tready)) begin
                    w_rd_issue = 1'b1;
                    n_rd_addr  = w_rd_inc;
                    n_rd_idx   = r_rd_idx + 1'b1;
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wp       <= '0;
            r_armed    <= 1'b0;
            r_cnt      <= '0;
            r_rd_addr  <= '0;
            r_rd_idx   <= '0;
            r_inflight <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_armed    <= n_armed;
            r_cnt      <= n_cnt;
            r_rd_addr  <= n_rd_addr;
            r_rd_idx   <= n_rd_idx;
            r_inflight <= w_rd_issue;
            if (r_inflight) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_issue) begin
            r_inf_idx  <= r_rd_idx;
            r_inf_last <= (r_rd_idx == LAST_IDX);
        end
        if (r_inflight) begin
            r_oframe <= w_rdata;
            r_oidx   <= r_inf_idx;
            r_olast  <= r_inf_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_oframe, r_oidx};
    assign m_axis_tlast  = r_olast;

    a_read_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_issue |-> (!r_ovalid || m_axis_tready))
        else $error("ring read issued while output register is held");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_issue |=> (r_inflight ##1 m_axis_tvalid))
        else $error("ring read did not reach the output");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == LAST_IDX))
        else $error("last frame flagged at wrong window position");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= LAST_ADDR) && (r_rd_addr <= LAST_ADDR))
        else $error("ring pointer out of range");

endmodule
